### rtl/dsil_pkg.sv
// Shared types for the depth sorted insert list.
// Item kinds, the stored entry record and the result record.
// No dependencies.
package dsil_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [11:0] mesh_index;
    logic [11:0] poly_index;
    logic [23:0] depth;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic [6:0]  entry_count;
    logic        entry_valid;
    entry_t      entry;
  } result_t;

endpackage

### rtl/dsil_cell.sv
// One list position of the depth sorted insert list.
// Holds an entry and shifts it to the next position on an insert.
// Depends on dsil_pkg.
module dsil_cell #(
  parameter int CNT_W = 7,
  parameter int IDX_W = 6,
  parameter int POS   = 0
) (
  input  logic                clk,
  input  logic                insert_en,
  input  logic [CNT_W-1:0]    count,
  input  logic [IDX_W-1:0]    read_index,
  input  dsil_pkg::entry_t    new_entry,
  input  logic                prev_gt,
  input  dsil_pkg::entry_t    prev_entry,
  output logic                gt,
  output dsil_pkg::entry_t    entry,
  output dsil_pkg::entry_t    read_data
);
  import dsil_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;
  logic   occupied;
  logic   at_end;

  assign occupied = count > CNT_W'(POS);
  assign at_end   = count == CNT_W'(POS);
  // New item goes before the first held entry that is strictly nearer
  assign gt       = occupied && (new_entry.depth > entry_r.depth);

  always_comb begin
    entry_nxt = entry_r;
    if (insert_en) begin
      if (prev_gt) begin
        entry_nxt = prev_entry;
      end else if (gt || at_end) begin
        entry_nxt = new_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry     = entry_r;
  assign read_data = (read_index == IDX_W'(POS)) ? entry_r : '0;

endmodule

### rtl/dsil_out_buf.sv
// Two-deep result buffer between the list and the result channel.
// Takes a result while an earlier one waits; stalls input only when full.
// Depends on dsil_pkg.
module dsil_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dsil_pkg::result_t  load_data,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output dsil_pkg::result_t  out_data
);
  import dsil_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    taken;

  assign taken = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (load) begin
      // load is never raised while the skid stage is occupied
      if (!main_valid_r || taken) begin
        main_nxt       = load_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = load_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (taken) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

### rtl/depth_sorted_insert_list_unit.sv
// Depth sorted insert list: a row of entry cells, farthest depth first.
// Items in: clear, insert or read; one result out for every item.
//
// Usage:
//   Present an item on in_kind and its fields with in_valid; it is taken
//   at a clock edge where in_valid is high and in_stall is low. A clear
//   empties the list, an insert places the entry before the first held
//   entry of strictly smaller depth (equal depths keep arrival order) and
//   is dropped with out_accepted low once CAPACITY entries are held, and
//   a read returns the entry at in_read_index or zeros past the count.
//   Every cell compares and shifts at once, so an insert completes at the
//   edge where it is taken: one item per cycle while in_stall is low; the
//   result is registered into the result buffer at that same edge.
//   A two-entry result buffer lets one more item in while a result waits
//   under out_stall; in_stall rises once both entries are held and falls
//   the cycle after the receiver takes one.
//   Reset (rst_n low, synchronous) empties the list and the buffer. The
//   entry cells themselves are not cleared; positions at or past the
//   count are never read.
module depth_sorted_insert_list_unit #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [11:0] in_mesh_index,
  input  logic [11:0] in_poly_index,
  input  logic [23:0] in_depth,
  input  logic [5:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic [6:0]  out_entry_count,
  output logic        out_entry_valid,
  output logic [11:0] out_mesh_index,
  output logic [11:0] out_poly_index,
  output logic [23:0] out_depth
);
  import dsil_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CNT_W > 6) ? CNT_W : 6;

  logic             accept;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             full;
  logic             insert_en;
  logic             buf_full;
  logic [IDX_W-1:0] ridx;
  entry_t           new_entry;
  entry_t           read_or;
  result_t          res;
  result_t          res_out;
  logic             hit;

  logic   gt_w   [CAPACITY];
  entry_t ent_w  [CAPACITY];
  entry_t rd_w   [CAPACITY];

  assign accept    = in_valid && !in_stall;
  assign full      = count_r == CNT_W'(CAPACITY);
  assign insert_en = accept && (kind_t'(in_kind) == KIND_INSERT) && !full;
  assign ridx      = IDX_W'(in_read_index);

  assign new_entry.mesh_index = in_mesh_index;
  assign new_entry.poly_index = in_poly_index;
  assign new_entry.depth      = in_depth;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
        dsil_cell #(.CNT_W(CNT_W), .IDX_W(IDX_W), .POS(g)) u_cell (
          .clk        (clk),
          .insert_en  (insert_en),
          .count      (count_r),
          .read_index (ridx),
          .new_entry  (new_entry),
          .prev_gt    (1'b0),
          .prev_entry (new_entry),
          .gt         (gt_w[g]),
          .entry      (ent_w[g]),
          .read_data  (rd_w[g])
        );
      end else begin : g_body
        dsil_cell #(.CNT_W(CNT_W), .IDX_W(IDX_W), .POS(g)) u_cell (
          .clk        (clk),
          .insert_en  (insert_en),
          .count      (count_r),
          .read_index (ridx),
          .new_entry  (new_entry),
          .prev_gt    (gt_w[g-1]),
          .prev_entry (ent_w[g-1]),
          .gt         (gt_w[g]),
          .entry      (ent_w[g]),
          .read_data  (rd_w[g])
        );
      end
    end
  endgenerate

  // Only the addressed cell drives non-zero read data
  always_comb begin
    read_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      read_or = read_or | rd_w[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      case (kind_t'(in_kind))
        KIND_CLEAR:  count_nxt = '0;
        KIND_INSERT: if (!full) count_nxt = count_r + CNT_W'(1);
        KIND_READ:   count_nxt = count_r;
        default:     count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign hit = (kind_t'(in_kind) == KIND_READ) && (ridx < IDX_W'(count_r));

  always_comb begin
    res             = '0;
    res.accepted    = insert_en;
    res.entry_count = 7'(count_nxt);
    res.entry_valid = hit;
    res.entry       = hit ? read_or : '0;
  end

  dsil_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .load_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_out)
  );

  assign in_stall        = buf_full;
  assign out_accepted    = res_out.accepted;
  assign out_entry_count = res_out.entry_count;
  assign out_entry_valid = res_out.entry_valid;
  assign out_mesh_index  = res_out.entry.mesh_index;
  assign out_poly_index  = res_out.entry.poly_index;
  assign out_depth       = res_out.entry.depth;

endmodule

### test/dsil_tb_pkg.sv
// Scoreboard for the depth sorted insert list testbench: a shadow copy of
// the sorted list and the queue of results still due from the block.
// Depends on dsil_pkg for the item kinds and the entry and result records.
`timescale 1ns / 1ps

package dsil_tb_pkg;
  import dsil_pkg::*;

  localparam int LIST_CAPACITY = 64;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  class depth_list_scoreboard;
    entry_t      shadow_list [LIST_CAPACITY];
    int unsigned shadow_count = 0;
    result_t     due_results [$];
    int unsigned fails = 0;
    int unsigned n_clear = 0, n_insert = 0, n_dropped = 0;
    int unsigned n_read = 0, n_read_hit = 0, n_unused = 0, n_checked = 0;

    function int unsigned pending();
      return due_results.size();
    endfunction

    function int unsigned count();
      return shadow_count;
    endfunction

    // Apply one accepted item to the shadow list and queue its result.
    function void note_item(logic [1:0] kind, entry_t item, logic [5:0] read_index);
      result_t     r;
      int unsigned slot;
      int          i;
      r = '0;
      case (kind)
        KIND_CLEAR: begin
          n_clear++;
          shadow_count = 0;
        end
        KIND_INSERT: begin
          n_insert++;
          if (shadow_count < LIST_CAPACITY) begin
            slot = shadow_count;
            // first entry strictly nearer than the new one; ties go after
            for (i = 0; i < shadow_count; i++) begin
              if (item.depth > shadow_list[i].depth) begin
                slot = i;
                break;
              end
            end
            for (i = shadow_count; i > slot; i--)
              shadow_list[i] = shadow_list[i - 1];
            shadow_list[slot] = item;
            shadow_count++;
            r.accepted = 1'b1;
          end else begin
            n_dropped++;
          end
        end
        KIND_READ: begin
          n_read++;
          if (read_index < shadow_count) begin
            n_read_hit++;
            r.entry_valid = 1'b1;
            r.entry = shadow_list[read_index];
          end
        end
        default: n_unused++;
      endcase
      r.entry_count = shadow_count[6:0];
      due_results.push_back(r);
    endfunction

    function void report(string field, logic [23:0] want, logic [23:0] got);
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        fails++;
        $display("%0t: result with nothing due, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = due_results.pop_front();
      n_checked++;
      if (got.accepted !== want.accepted)
        report("accepted", want.accepted, got.accepted);
      if (got.entry_count !== want.entry_count)
        report("entry_count", want.entry_count, got.entry_count);
      if (got.entry_valid !== want.entry_valid)
        report("entry_valid", want.entry_valid, got.entry_valid);
      if (got.entry.mesh_index !== want.entry.mesh_index)
        report("mesh_index", want.entry.mesh_index, got.entry.mesh_index);
      if (got.entry.poly_index !== want.entry.poly_index)
        report("poly_index", want.entry.poly_index, got.entry.poly_index);
      if (got.entry.depth !== want.entry.depth)
        report("depth", want.entry.depth, got.entry.depth);
    endfunction
  endclass

endpackage

### test/testbench.sv
// Top of the depth sorted insert list testbench: clock, reset, item driver,
// receiver stall pattern, monitors and the directed and random sequences.
// Depends on dsil_pkg, dsil_tb_pkg and depth_sorted_insert_list_unit.
`timescale 1ns / 1ps

module testbench;
  import dsil_pkg::*;
  import dsil_tb_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_CLEAR;
  logic [11:0] in_mesh_index = '0;
  logic [11:0] in_poly_index = '0;
  logic [23:0] in_depth = '0;
  logic [5:0]  in_read_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_accepted;
  logic [6:0]  out_entry_count;
  logic        out_entry_valid;
  logic [11:0] out_mesh_index;
  logic [11:0] out_poly_index;
  logic [23:0] out_depth;

  depth_list_scoreboard sb = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_span = 0;
  int unsigned stall_mode = 0;
  logic        moved;

  depth_sorted_insert_list_unit #(
    .CAPACITY(LIST_CAPACITY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_mesh_index(in_mesh_index),
    .in_poly_index(in_poly_index),
    .in_depth(in_depth),
    .in_read_index(in_read_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_accepted(out_accepted),
    .out_entry_count(out_entry_count),
    .out_entry_valid(out_entry_valid),
    .out_mesh_index(out_mesh_index),
    .out_poly_index(out_poly_index),
    .out_depth(out_depth)
  );

  always #6 clk = ~clk;

  // Check results before noting items so an early result never meets its own item.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        sb.check_result({out_accepted, out_entry_count, out_entry_valid,
                         out_mesh_index, out_poly_index, out_depth});
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_item(in_kind, {in_mesh_index, in_poly_index, in_depth}, in_read_index);
        moved = 1'b1;
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver stall: switch between free running, light, heavy and periodic stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(20, 200);
      end
      stall_span = stall_span - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_span % 16) < 9);
      endcase
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic [1:0] kind, input logic [11:0] mesh,
                           input logic [11:0] poly, input logic [23:0] depth,
                           input logic [5:0] read_index);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left = burst_left - 1;
    in_valid      = 1'b1;
    in_kind       = kind;
    in_mesh_index = mesh;
    in_poly_index = poly;
    in_depth      = depth;
    in_read_index = read_index;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic send_insert(input logic [23:0] depth);
    send_item(KIND_INSERT, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              depth, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_read(input logic [5:0] read_index);
    send_item(KIND_READ, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              24'($urandom()), read_index);
  endtask

  task automatic read_somewhere();
    int unsigned held;
    held = sb.count();
    if (held > 0 && $urandom_range(0, 1) == 1)
      send_read(6'($urandom_range(0, held - 1)));
    else
      send_read(6'($urandom_range(0, 63)));
  endtask

  // Hold the sender until every due result has come back.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    int i;
    send_read(6'd0);
    send_read(6'd63);
    send_item(KIND_UNUSED, 12'hFFF, 12'hFFF, 24'hFFFFFF, 6'd63);
    send_item(KIND_INSERT, 12'h000, 12'h000, 24'h000000, 6'd0);
    send_item(KIND_INSERT, 12'hFFF, 12'hFFF, 24'hFFFFFF, 6'd63);
    // equal depths must keep arrival order
    send_item(KIND_INSERT, 12'h001, 12'h011, 24'h000000, 6'd0);
    send_item(KIND_INSERT, 12'h002, 12'h022, 24'h800000, 6'd0);
    send_item(KIND_INSERT, 12'h003, 12'h033, 24'h800000, 6'd0);
    send_item(KIND_INSERT, 12'h004, 12'h044, 24'hFFFFFF, 6'd0);
    for (i = 0; i <= 6; i++) send_read(6'(i));
    send_read(6'd63);
    send_item(KIND_CLEAR, 12'hABC, 12'h123, 24'h5A5A5A, 6'd21);
    send_read(6'd0);
    send_item(KIND_INSERT, 12'h555, 12'hAAA, 24'h000001, 6'd42);
    send_read(6'd0);
    send_item(KIND_UNUSED, 12'h000, 12'h000, 24'h000000, 6'd0);
    send_item(KIND_CLEAR, 12'h000, 12'h000, 24'h000000, 6'd0);
  endtask

  // One frame: usually a clear, a run of inserts with reads among them, then a sweep.
  task automatic run_frame();
    int          n, i, mode;
    int unsigned held;
    logic [23:0] flat, depth;
    mode = $urandom_range(0, 2);
    flat = 24'($urandom());
    if ($urandom_range(0, 4) != 0)
      send_item(KIND_CLEAR, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                24'($urandom()), 6'($urandom_range(0, 63)));
    n = ($urandom_range(0, 3) == 0) ? LIST_CAPACITY + $urandom_range(1, 6)
                                    : $urandom_range(1, 24);
    for (i = 0; i < n; i++) begin
      case (mode)
        0: depth = 24'($urandom());
        1: begin
          case ($urandom_range(0, 4))
            0: depth = 24'h000000;
            1: depth = 24'hFFFFFF;
            2: depth = 24'h800000;
            3: depth = 24'h000001;
            default: depth = 24'h7FFFFF;
          endcase
        end
        default: depth = flat;
      endcase
      send_insert(depth);
      if ($urandom_range(0, 4) == 0) read_somewhere();
      if ($urandom_range(0, 24) == 0)
        send_item(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)), 24'($urandom()),
                  6'($urandom_range(0, 63)));
    end
    held = sb.count();
    if (held <= 16) begin
      for (i = 0; i <= held && i < LIST_CAPACITY; i++) send_read(6'(i));
    end else begin
      repeat (16) read_somewhere();
    end
    send_read(6'd63);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    drain();
    while (items_sent < ITEM_TARGET) begin
      run_frame();
      if ($urandom_range(0, 5) == 0) drain();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d clears, %0d inserts (%0d dropped on a full list),",
             sb.n_checked, sb.n_clear, sb.n_insert, sb.n_dropped);
    $display("%0d reads (%0d in range) and %0d items of the unused kind.",
             sb.n_read, sb.n_read_hit, sb.n_unused);
    if (sb.fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.fails);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
